@@ rtl/aarc_pkg.sv @@
// Package for the attitude axis rate controller.
// Holds the fixed-point constants, the axis and register codes and the stage payload types.
package aarc_pkg;

  localparam int AngleFracBits = 24;
  localparam int LevelFracBits = 15;

  // Degree thresholds in Q8.24 radians.
  localparam logic [31:0] RadP15   = 32'd43923;
  localparam logic [31:0] RadP01   = 32'd2928;
  localparam logic [31:0] Rad1P00  = 32'd292818;
  localparam logic [31:0] RadP25   = 32'd73204;
  localparam logic [31:0] Rad3P00  = 32'd878453;
  localparam logic [31:0] RadP50   = 32'd146409;
  localparam logic [31:0] Rad10P0  = 32'd2928177;
  localparam logic [31:0] Rad2P00  = 32'd585635;

  localparam logic [1:0] AxisInvalid = 2'd3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegInertiaPitch = 3'd0,
    RegInertiaYaw   = 3'd1,
    RegInertiaRoll  = 3'd2,
    RegTorquePitch  = 3'd3,
    RegTorqueYaw    = 3'd4,
    RegTorqueRoll   = 3'd5
  } cfg_reg_t;

  // Numerator: err(33) * mass(24) * inertia(32) * 1e6(20) fits in 109 bits.
  localparam int NumW = 110;
  // Denominator: step(20) * torque(32) << 40 fits in 92 bits; shifted by 15 more.
  localparam int DenW = 110;
  localparam int LevelW = LevelFracBits + 1;

  typedef struct packed {
    logic              valid;
    logic              axis_error;
    logic              settled;
    logic [2:0]        thruster_group;
    logic [31:0]       target_rate;
    logic [LevelW-1:0] level;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
  } cell_t;

endpackage

@@ rtl/aarc_div_cell.sv @@
// One restoring division cell of the level pipeline: decides one quotient bit.
// Depends on aarc_pkg.
module aarc_div_cell import aarc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  bit_sel,
  input  cell_t       cell_in,
  output cell_t       cell_out
);

  cell_t cell_r;
  cell_t cell_nxt;
  logic [NumW-1:0] trial;

  always_comb begin
    cell_nxt = cell_in;
    trial = NumW'(cell_in.den << bit_sel);
    if (cell_in.valid && !cell_in.settled && !cell_in.axis_error
        && !cell_in.level[LevelW-1] && cell_in.num >= trial) begin
      cell_nxt.num = cell_in.num - trial;
      cell_nxt.level[bit_sel] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.axis_error     <= cell_nxt.axis_error;
    cell_r.settled        <= cell_nxt.settled;
    cell_r.thruster_group <= cell_nxt.thruster_group;
    cell_r.target_rate    <= cell_nxt.target_rate;
    cell_r.level          <= cell_nxt.level;
    cell_r.num            <= cell_nxt.num;
    cell_r.den            <= cell_nxt.den;
  end

  assign cell_out = cell_r;

endmodule

@@ rtl/aarc_front.sv @@
// Front stages: schedule, rate deadband, and the products for the level division.
// Depends on aarc_pkg.
module aarc_front import aarc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         axis,
  input  logic signed [31:0] target_angle,
  input  logic signed [31:0] current_angle,
  input  logic signed [31:0] current_rate,
  input  logic [30:0]        angle_deadband,
  input  logic [23:0]        vessel_mass,
  input  logic [19:0]        step_time,
  input  logic [31:0]        inertia,
  input  logic [31:0]        torque,
  output cell_t              cell_out
);

  // Stage 1: schedule and rate error.
  logic        v1_r, ae1_r, st1_r, neg1_r;
  logic [1:0]  ax1_r;
  logic [31:0] tr1_r;
  logic [32:0] em1_r;
  logic [23:0] m1_r;
  logic [19:0] s1_r;
  logic [31:0] in1_r, tq1_r;

  logic signed [32:0] d_ang, trate, rerr;
  logic [32:0] mag, em, half, rdb;
  logic [31:0] r;

  always_comb begin
    d_ang = 33'(target_angle) - 33'(current_angle);
    mag = d_ang[32] ? 33'(-d_ang) : 33'(d_ang);
    if (mag < 33'(RadP15))       r = RadP01;
    else if (mag < 33'(Rad1P00)) r = RadP25;
    else if (mag < 33'(Rad3P00)) r = RadP50;
    else if (mag < 33'(Rad10P0)) r = Rad1P00;
    else                         r = Rad2P00;
    if (mag <= 33'(angle_deadband)) trate = '0;
    else trate = d_ang[32] ? -33'(r) : 33'(r);
    rerr = trate - 33'(current_rate);
    em = rerr[32] ? 33'(-rerr) : 33'(rerr);
    half = 33'(r) >> 1;
    if (mag <= 33'(angle_deadband)) half = '0;
    rdb = (half < 33'(RadP01)) ? half : 33'(RadP01);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    ae1_r  <= (axis == AxisInvalid);
    st1_r  <= (em <= rdb);
    neg1_r <= rerr[32];
    ax1_r  <= axis;
    tr1_r  <= trate[31:0];
    em1_r  <= em;
    m1_r   <= vessel_mass;
    s1_r   <= step_time;
    in1_r  <= inertia;
    tq1_r  <= torque;
  end

  // Stage 2: first products; the one-million scale is folded into the inertia.
  logic        v2_r, ae2_r, st2_r, neg2_r;
  logic [1:0]  ax2_r;
  logic [31:0] tr2_r;
  logic [51:0] ik2_r;
  logic [56:0] em_m2_r;
  logic [51:0] st_t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    ae2_r   <= ae1_r;
    st2_r   <= st1_r;
    neg2_r  <= neg1_r;
    ax2_r   <= ax1_r;
    tr2_r   <= tr1_r;
    ik2_r   <= 52'(in1_r) * 52'(20'd1000000);
    em_m2_r <= 57'(em1_r) * 57'(m1_r);
    st_t2_r <= 52'(s1_r) * 52'(tq1_r);
  end

  // Stage 3: cross products of the two factors, each cut into two halves.
  logic        v3_r, ae3_r, st3_r, neg3_r;
  logic [1:0]  ax3_r;
  logic [31:0] tr3_r;
  logic [54:0] p_ll3_r, p_lh3_r, p_hl3_r, p_hh3_r;
  logic [51:0] st_t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    ae3_r   <= ae2_r;
    st3_r   <= st2_r;
    neg3_r  <= neg2_r;
    ax3_r   <= ax2_r;
    tr3_r   <= tr2_r;
    st_t3_r <= st_t2_r;
    p_ll3_r <= 55'(em_m2_r[28:0]) * 55'(ik2_r[25:0]);
    p_lh3_r <= 55'(em_m2_r[28:0]) * 55'(ik2_r[51:26]);
    p_hl3_r <= 55'(em_m2_r[56:29]) * 55'(ik2_r[25:0]);
    p_hh3_r <= 55'(em_m2_r[56:29]) * 55'(ik2_r[51:26]);
  end

  // Stage 4: sum the partial products into the numerator and form the shifted denominator.
  logic [NumW-1:0] num_n;
  logic [DenW-1:0] den_n;
  cell_t c4_r;

  always_comb begin
    num_n = NumW'(p_ll3_r) + (NumW'(p_lh3_r) << 26) + (NumW'(p_hl3_r) << 29)
            + (NumW'(p_hh3_r) << 55);
    den_n = DenW'(st_t3_r) << (16 + AngleFracBits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c4_r.valid <= 1'b0;
    else c4_r.valid <= v3_r;
    c4_r.axis_error     <= ae3_r;
    c4_r.settled        <= st3_r;
    c4_r.thruster_group <= {ax3_r, 1'b0} | {2'b00, neg3_r & ~st3_r};
    c4_r.target_rate    <= tr3_r;
    c4_r.num            <= num_n;
    c4_r.den            <= den_n;
    c4_r.level          <= '0;
  end

  assign cell_out = c4_r;

endmodule

@@ rtl/attitude_axis_rate_controller_unit.sv @@
// Each update runs from start to out_strobe through four front stages
// (schedule, products) and a row of sixteen division cells, one per level
// bit. A new update is accepted every cycle; busy is always low. The
// receiver cannot stall; each result shows for one cycle.
// Top level; depends on aarc_pkg, aarc_front and aarc_div_cell.
module attitude_axis_rate_controller_unit import aarc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_target_angle,
  input  logic signed [31:0] in_current_angle,
  input  logic signed [31:0] in_current_rate,
  input  logic [30:0]        in_angle_deadband,
  input  logic [23:0]        in_vessel_mass,
  input  logic [19:0]        in_step_time,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_strobe,
  output logic               out_settled,
  output logic [2:0]         out_thruster_group,
  output logic [15:0]        out_fire_level,
  output logic signed [31:0] out_target_rate,
  output logic               out_axis_error
);

  logic [31:0] inertia_r [3];
  logic [31:0] torque_r [3];
  logic [31:0] inertia, torque;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        inertia_r[i] <= 32'd65536;
        torque_r[i]  <= 32'd1;
      end
    end else if (cfg_we) begin
      if (cfg_index <= RegInertiaRoll) inertia_r[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index <= RegTorqueRoll) torque_r[2'(cfg_index - RegTorquePitch)] <= cfg_data;
    end
  end

  always_comb begin
    inertia = (in_axis == AxisInvalid) ? '0 : inertia_r[in_axis];
    torque  = (in_axis == AxisInvalid) ? '0 : torque_r[in_axis];
  end

  assign busy = 1'b0;

  cell_t chain [LevelW+1];

  aarc_front u_front (
    .clk, .rst_n, .start,
    .axis(in_axis), .target_angle(in_target_angle), .current_angle(in_current_angle),
    .current_rate(in_current_rate), .angle_deadband(in_angle_deadband),
    .vessel_mass(in_vessel_mass), .step_time(in_step_time),
    .inertia, .torque, .cell_out(chain[0])
  );

  // The first cell tests the saturating bit; once it is set the rest pass the beat on.
  for (genvar g = 0; g < LevelW; g++) begin : g_cell
    aarc_div_cell u_cell (
      .clk, .rst_n, .bit_sel(4'(LevelW - 1 - g)),
      .cell_in(chain[g]), .cell_out(chain[g+1])
    );
  end

  cell_t last;
  assign last = chain[LevelW];

  assign out_strobe         = last.valid;
  assign out_axis_error     = last.axis_error;
  assign out_settled        = !last.axis_error && last.settled;
  assign out_thruster_group = last.axis_error ? 3'd0 : last.thruster_group;
  assign out_target_rate    = last.axis_error ? '0 : last.target_rate;
  assign out_fire_level     = (last.axis_error || last.settled) ? 16'd0 :
                              16'(last.level);

endmodule
